@@ src/bdpc_pkg.sv @@
package bdpc_pkg;

	localparam int TIME_BITS = 32;
	localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;
	localparam int NUM_BUTTONS = 3;
	localparam int ADDR_W = 3;

	localparam logic [31:0] DEBOUNCE_US_RESET = 32'd20000;
	localparam logic [31:0] HOLD_US_RESET = 32'd500000;

	// Register select is the word bit of the byte address.
	localparam logic REG_DEBOUNCE = 1'b0;
	localparam logic REG_HOLD = 1'b1;

	localparam int BTN_LEFT = 0;
	localparam int BTN_RIGHT = 1;
	localparam int BTN_CENTRE = 2;

	typedef logic [TIME_BITS-1:0] time_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_DOWN,
		PH_ACCEPT
	} phase_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_PRESSED,
		ACT_PENDING,
		ACT_LONG,
		ACT_HOLDING
	} act_t;

	typedef struct packed {
		act_t left;
		act_t right;
		logic dual;
	} chord_res_t;

	function automatic logic elapsed_gt(time_t now, time_t start, logic [31:0] limit);
		time_t diff;
		diff = now - start;
		return CMP_W'(diff) > CMP_W'(limit);
	endfunction

endpackage

@@ src/bdpc_if.sv @@
interface bdpc_poll_if;
	logic valid;
	logic ready;
	logic left_pin;
	logic right_pin;
	logic centre_pin;
	logic [31:0] now_us;

	modport source (output valid, left_pin, right_pin, centre_pin, now_us, input ready);
	modport sink (input valid, left_pin, right_pin, centre_pin, now_us, output ready);
endinterface

interface bdpc_result_if;
	logic valid;
	logic ready;
	logic [2:0] left_action;
	logic [2:0] right_action;
	logic [2:0] centre_action;
	logic dual_press;

	modport source (output valid, left_action, right_action, centre_action, dual_press,
		input ready);
	modport sink (input valid, left_action, right_action, centre_action, dual_press,
		output ready);
endinterface

@@ src/bdpc_lane.sv @@
module bdpc_lane (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               pin,
	input  bdpc_pkg::time_t    now,
	input  logic [31:0]        debounce_us,
	input  logic [31:0]        hold_us,
	output bdpc_pkg::act_t     action
);
	import bdpc_pkg::*;

	phase_t deb_phase_q, deb_phase_d;
	time_t  deb_start_q, deb_start_d;
	phase_t act_phase_q, act_phase_d;
	time_t  act_start_q, act_start_d;
	logic   pressed;
	logic   down;

	assign pressed = ~pin;

	// Debouncer: a press is accepted once it has lasted longer than debounce_us.
	always_comb begin
		deb_phase_d = deb_phase_q;
		deb_start_d = deb_start_q;
		down = 1'b0;
		unique case (deb_phase_q)
			PH_DOWN: begin
				if (!pressed) begin
					deb_phase_d = PH_IDLE;
				end else if (elapsed_gt(now, deb_start_q, debounce_us)) begin
					deb_phase_d = PH_ACCEPT;
					down = 1'b1;
				end
			end
			PH_ACCEPT: begin
				if (!pressed) begin
					deb_phase_d = PH_IDLE;
				end else begin
					down = 1'b1;
				end
			end
			default: begin
				deb_phase_d = PH_IDLE;
				if (pressed) begin
					deb_phase_d = PH_DOWN;
					deb_start_d = now;
				end
			end
		endcase
	end

	// Classifier on the debounced level.
	always_comb begin
		act_phase_d = act_phase_q;
		act_start_d = act_start_q;
		action = ACT_NONE;
		unique case (act_phase_q)
			PH_DOWN: begin
				if (!down) begin
					act_phase_d = PH_IDLE;
					action = ACT_PRESSED;
				end else if (elapsed_gt(now, act_start_q, hold_us)) begin
					act_phase_d = PH_ACCEPT;
					action = ACT_LONG;
				end else begin
					action = ACT_PENDING;
				end
			end
			PH_ACCEPT: begin
				if (!down) begin
					act_phase_d = PH_IDLE;
				end else begin
					action = ACT_HOLDING;
				end
			end
			default: begin
				act_phase_d = PH_IDLE;
				if (down) begin
					act_phase_d = PH_DOWN;
					act_start_d = now;
					action = ACT_PENDING;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_phase_q <= PH_IDLE;
			act_phase_q <= PH_IDLE;
		end else if (step) begin
			deb_phase_q <= deb_phase_d;
			act_phase_q <= act_phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			deb_start_q <= deb_start_d;
			act_start_q <= act_start_d;
		end
	end

	a_holding_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		action == ACT_HOLDING |-> act_phase_q == PH_ACCEPT && deb_phase_q == PH_ACCEPT)
		else $error("holding reported without an accepted press");

	a_pressed_on_release: assert property (@(posedge clk) disable iff (!arst_n)
		action == ACT_PRESSED |-> deb_phase_d == PH_IDLE)
		else $error("short press reported while the debouncer still sees the button down");

	a_pending_starts: assert property (@(posedge clk) disable iff (!arst_n)
		step && act_phase_q == PH_IDLE && action == ACT_PENDING |=> act_phase_q == PH_DOWN)
		else $error("classifier did not enter the pressed phase");

endmodule

@@ src/bdpc_chord.sv @@
module bdpc_chord (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  bdpc_pkg::act_t        left_raw,
	input  bdpc_pkg::act_t        right_raw,
	output bdpc_pkg::chord_res_t  res
);
	import bdpc_pkg::*;

	logic chord_active_q, chord_active_d;

	// While a chord lasts, both reported codes read none until both raw codes do.
	always_comb begin
		chord_active_d = chord_active_q;
		res.left = left_raw;
		res.right = right_raw;
		res.dual = 1'b0;
		if (!chord_active_q) begin
			if (left_raw != ACT_NONE && right_raw != ACT_NONE) begin
				chord_active_d = 1'b1;
				res.dual = (left_raw == ACT_PENDING) && (right_raw == ACT_PENDING);
				res.left = ACT_NONE;
				res.right = ACT_NONE;
			end
		end else begin
			if (left_raw == ACT_NONE && right_raw == ACT_NONE) begin
				chord_active_d = 1'b0;
			end
			res.left = ACT_NONE;
			res.right = ACT_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chord_active_q <= 1'b0;
		end else if (step) begin
			chord_active_q <= chord_active_d;
		end
	end

	a_dual_suppresses: assert property (@(posedge clk) disable iff (!arst_n)
		res.dual |-> res.left == ACT_NONE && res.right == ACT_NONE)
		else $error("dual press reported with unsuppressed codes");

	a_dual_starts_chord: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.dual |=> chord_active_q)
		else $error("dual press did not start a chord");

	a_chord_ends: assert property (@(posedge clk) disable iff (!arst_n)
		step && chord_active_q && left_raw == ACT_NONE && right_raw == ACT_NONE
		|=> !chord_active_q)
		else $error("chord did not end after both buttons released");

	a_active_suppresses: assert property (@(posedge clk) disable iff (!arst_n)
		chord_active_q |-> res.left == ACT_NONE && res.right == ACT_NONE && !res.dual)
		else $error("codes leaked during an active chord");

endmodule

@@ src/button_debounce_press_classifier.sv @@
// Channel   Dir  Payload                                              Transfer
// poll      in   left_pin, right_pin, centre_pin, now_us[31:0]        valid & ready
// result    out  left/right/centre_action[2:0], dual_press            valid & ready
// apb       in   paddr[2:0], pwdata[31:0] -> prdata[31:0]             psel & penable & pready
//
// One poll per cycle: all three button lanes and the chord merge update in the cycle of
// the transfer, and the result sits in one output register.
// Throughput is set only by the output register: a poll is taken whenever that register
// is empty or is being drained in the same cycle.
// Reset clears all phases, the chord flag and the output valid; registers take their
// default times. A stalled result holds its register and stalls the poll channel.
module button_debounce_press_classifier (
	input  logic                           clk,
	input  logic                           arst_n,
	bdpc_poll_if.sink                      poll,
	bdpc_result_if.source                  result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bdpc_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import bdpc_pkg::*;

	logic [31:0] debounce_us_q;
	logic [31:0] hold_us_q;
	logic        step;
	time_t       now;
	logic [NUM_BUTTONS-1:0] pins;
	act_t        raw [NUM_BUTTONS];
	chord_res_t  chord_res;

	logic        valid_s1;
	act_t        left_s1;
	act_t        right_s1;
	act_t        centre_s1;
	logic        dual_s1;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_us_q <= DEBOUNCE_US_RESET;
			hold_us_q <= HOLD_US_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_DEBOUNCE: debounce_us_q <= pwdata;
				REG_HOLD: hold_us_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_DEBOUNCE: prdata = debounce_us_q;
			REG_HOLD: prdata = hold_us_q;
			default: prdata = '0;
		endcase
	end

	assign poll.ready = !valid_s1 || result.ready;
	assign step = poll.valid && poll.ready;
	assign now = TIME_BITS'(poll.now_us);
	assign pins[BTN_LEFT] = poll.left_pin;
	assign pins[BTN_RIGHT] = poll.right_pin;
	assign pins[BTN_CENTRE] = poll.centre_pin;

	for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
		bdpc_lane u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.step        (step),
			.pin         (pins[b]),
			.now         (now),
			.debounce_us (debounce_us_q),
			.hold_us     (hold_us_q),
			.action      (raw[b])
		);
	end

	bdpc_chord u_chord (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.left_raw  (raw[BTN_LEFT]),
		.right_raw (raw[BTN_RIGHT]),
		.res       (chord_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			left_s1 <= chord_res.left;
			right_s1 <= chord_res.right;
			centre_s1 <= raw[BTN_CENTRE];
			dual_s1 <= chord_res.dual;
		end
	end

	assign result.valid = valid_s1;
	assign result.left_action = 3'(left_s1);
	assign result.right_action = 3'(right_s1);
	assign result.centre_action = 3'(centre_s1);
	assign result.dual_press = dual_s1;

endmodule

@@ sim/bdpc_action_checker.sv @@
`timescale 1ns / 1ps

module bdpc_action_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	bdpc_poll_if                        poll,
	bdpc_result_if                      result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [bdpc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output int                          errors,
	output int                          outstanding
);
	import bdpc_pkg::*;

	typedef struct packed {
		act_t left;
		act_t right;
		act_t centre;
		logic dual;
	} actions_t;

	phase_t      deb_phase [NUM_BUTTONS];
	time_t       deb_since [NUM_BUTTONS];
	phase_t      cls_phase [NUM_BUTTONS];
	time_t       cls_since [NUM_BUTTONS];
	logic        chord_on;
	logic [31:0] debounce_lim;
	logic [31:0] hold_lim;
	actions_t    expected_actions[$];
	int          fail_cnt = 0;
	int          waiting = 0;

	assign errors = fail_cnt;
	assign outstanding = waiting;

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("%0t ns: mismatch on %s, got %0d, expected %0d", $time, what, got, want);
		fail_cnt++;
	endtask

	// One button lane: debounce the raw level, then turn the debounced level into an action.
	function automatic act_t button_action(input int b, input logic pressed, input time_t now);
		logic down;
		act_t act;
		down = 1'b0;
		case (deb_phase[b])
			PH_DOWN: begin
				if (!pressed) begin
					deb_phase[b] = PH_IDLE;
				end else if (time_t'(now - deb_since[b]) > debounce_lim) begin
					deb_phase[b] = PH_ACCEPT;
					down = 1'b1;
				end
			end
			PH_ACCEPT: begin
				if (!pressed)
					deb_phase[b] = PH_IDLE;
				else
					down = 1'b1;
			end
			default: begin
				deb_phase[b] = pressed ? PH_DOWN : PH_IDLE;
				if (pressed)
					deb_since[b] = now;
			end
		endcase

		act = ACT_NONE;
		case (cls_phase[b])
			PH_DOWN: begin
				if (!down) begin
					cls_phase[b] = PH_IDLE;
					act = ACT_PRESSED;
				end else if (time_t'(now - cls_since[b]) > hold_lim) begin
					cls_phase[b] = PH_ACCEPT;
					act = ACT_LONG;
				end else begin
					act = ACT_PENDING;
				end
			end
			PH_ACCEPT: begin
				if (!down)
					cls_phase[b] = PH_IDLE;
				else
					act = ACT_HOLDING;
			end
			default: begin
				cls_phase[b] = down ? PH_DOWN : PH_IDLE;
				if (down) begin
					cls_since[b] = now;
					act = ACT_PENDING;
				end
			end
		endcase
		return act;
	endfunction

	function automatic actions_t predict_actions(input logic lp, input logic rp, input logic cp,
		input time_t now);
		actions_t res;
		res.dual = 1'b0;
		res.left = button_action(BTN_LEFT, !lp, now);
		res.right = button_action(BTN_RIGHT, !rp, now);
		// The chord holds both side codes at none until both raw codes have gone back to none.
		if (!chord_on) begin
			if (res.left == ACT_PENDING && res.right == ACT_PENDING) begin
				chord_on = 1'b1;
				res.dual = 1'b1;
				res.left = ACT_NONE;
				res.right = ACT_NONE;
			end else if (res.left != ACT_NONE && res.right != ACT_NONE) begin
				chord_on = 1'b1;
				res.left = ACT_NONE;
				res.right = ACT_NONE;
			end
		end else begin
			if (res.left == ACT_NONE && res.right == ACT_NONE)
				chord_on = 1'b0;
			res.left = ACT_NONE;
			res.right = ACT_NONE;
		end
		res.centre = button_action(BTN_CENTRE, !cp, now);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		actions_t want;
		if (!arst_n) begin
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				deb_phase[b] = PH_IDLE;
				cls_phase[b] = PH_IDLE;
			end
			chord_on = 1'b0;
			debounce_lim = DEBOUNCE_US_RESET;
			hold_lim = HOLD_US_RESET;
			expected_actions.delete();
			waiting <= 0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_actions.size() == 0) begin
					flag_mismatch("unexpected result transfer", 1, 0);
				end else begin
					want = expected_actions.pop_front();
					if (result.left_action !== want.left)
						flag_mismatch("left_action", int'(result.left_action), int'(want.left));
					if (result.right_action !== want.right)
						flag_mismatch("right_action", int'(result.right_action), int'(want.right));
					if (result.centre_action !== want.centre)
						flag_mismatch("centre_action", int'(result.centre_action),
							int'(want.centre));
					if (result.dual_press !== want.dual)
						flag_mismatch("dual_press", int'(result.dual_press), int'(want.dual));
				end
			end
			if (poll.valid && poll.ready)
				expected_actions.push_back(predict_actions(poll.left_pin, poll.right_pin,
					poll.centre_pin, poll.now_us));
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_HOLD)
					hold_lim = pwdata;
				else
					debounce_lim = pwdata;
			end
			waiting <= expected_actions.size();
		end
	end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import bdpc_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	int                fails;
	int                outstanding;

	logic [15:0] ready_pat = 16'hFFFF;
	logic [3:0]  ready_idx = 4'd0;
	logic [31:0] cfg_debounce = DEBOUNCE_US_RESET;
	logic [31:0] cfg_hold = HOLD_US_RESET;
	logic [31:0] clock_us;
	logic [2:0]  pins;

	bdpc_poll_if   poll_ch();
	bdpc_result_if res_ch();

	button_debounce_press_classifier uut (
		.clk    (clk),
		.arst_n (arst_n),
		.poll   (poll_ch),
		.result (res_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	bdpc_action_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.poll       (poll_ch),
		.result     (res_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.errors     (fails),
		.outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// The receiver follows a rotating stall pattern that each phase may replace.
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			res_ch.ready <= ready_pat[ready_idx];
			ready_idx <= ready_idx + 4'd1;
		end
	end

	task automatic send_poll(input logic lp, input logic rp, input logic cp,
		input logic [31:0] now);
		poll_ch.valid <= 1'b1;
		poll_ch.left_pin <= lp;
		poll_ch.right_pin <= rp;
		poll_ch.centre_pin <= cp;
		poll_ch.now_us <= now;
		do @(posedge clk); while (!poll_ch.ready);
	endtask

	task automatic reg_write(input logic sel, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({sel, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain();
		poll_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Time between polls, biased toward the thresholds so that both sides of each compare show up.
	function automatic logic [31:0] poll_interval();
		logic [31:0] span;
		span = (cfg_debounce >> 2) + (cfg_hold >> 3) + 32'd4;
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return 32'd1;
			2: return cfg_debounce;
			3: return cfg_debounce + 32'd1;
			4: return cfg_hold;
			5: return cfg_hold + 32'd1;
			6: return $urandom;
			default: return $urandom_range(0, span);
		endcase
	endfunction

	task automatic run_phase(input int n_items, input bit steady);
		int run_len;
		int burst;
		bit tie_lr;
		run_len = $urandom_range(2, 10);
		burst = $urandom_range(1, 20);
		tie_lr = 1'b1;
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				pins = 3'($urandom);
			end else begin
				if ($urandom_range(0, 15) == 0)
					tie_lr = 1'($urandom);
				if ($urandom_range(0, run_len) == 0)
					pins[0] = ~pins[0];
				if (tie_lr)
					pins[1] = pins[0];
				else if ($urandom_range(0, run_len) == 0)
					pins[1] = ~pins[1];
				if ($urandom_range(0, run_len) == 0)
					pins[2] = ~pins[2];
			end
			clock_us = clock_us + poll_interval();
			send_poll(pins[0], pins[1], pins[2], clock_us);
			burst--;
			if (burst == 0) begin
				burst = $urandom_range(1, 20);
				if (!steady) begin
					poll_ch.valid <= 1'b0;
					repeat ($urandom_range(1, 6)) @(posedge clk);
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		poll_ch.valid = 1'b0;
		poll_ch.left_pin = 1'b1;
		poll_ch.right_pin = 1'b1;
		poll_ch.centre_pin = 1'b1;
		poll_ch.now_us = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default thresholds: chord with dual press, long press, short press,
		// chord without pending, timestamp wrap and glitches.
		send_poll(1, 1, 1, 32'd0);
		send_poll(0, 0, 0, 32'd0);
		send_poll(0, 0, 0, 32'd20000);
		send_poll(0, 0, 0, 32'd20001);
		send_poll(0, 0, 0, 32'd520001);
		send_poll(0, 0, 0, 32'd520002);
		send_poll(0, 0, 0, 32'd600000);
		send_poll(1, 1, 1, 32'd600001);
		send_poll(0, 1, 1, 32'd700000);
		send_poll(0, 1, 1, 32'd720001);
		send_poll(1, 1, 1, 32'd720002);
		send_poll(0, 1, 0, 32'd800000);
		send_poll(0, 1, 0, 32'd820001);
		send_poll(0, 1, 0, 32'd1400000);
		send_poll(0, 0, 0, 32'd1400001);
		send_poll(0, 0, 0, 32'd1500000);
		send_poll(0, 1, 1, 32'd1500001);
		send_poll(1, 1, 1, 32'd1500002);
		send_poll(0, 0, 0, 32'hFFFF_FFF0);
		send_poll(0, 0, 0, 32'h0000_4E30);
		send_poll(1, 0, 1, 32'hFFFF_FFFF);
		send_poll(0, 1, 0, 32'h7FFF_FFFF);
		send_poll(1, 1, 1, 32'h8000_0000);
		drain();

		clock_us = 32'h8000_0000;
		pins = 3'b111;
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: begin cfg_debounce = 32'd0; cfg_hold = 32'd0; end
				1: begin cfg_debounce = 32'hFFFF_FFFF; cfg_hold = 32'hFFFF_FFFF; end
				2: begin cfg_debounce = 32'd3; cfg_hold = 32'd10; end
				3: begin cfg_debounce = 32'd1; cfg_hold = 32'd0; end
				4: begin cfg_debounce = 32'd0; cfg_hold = 32'd5; end
				5: begin cfg_debounce = DEBOUNCE_US_RESET; cfg_hold = HOLD_US_RESET; end
				6: begin cfg_debounce = 32'd100; cfg_hold = 32'hFFFF_FFFF; end
				7: begin cfg_debounce = 32'hFFFF_FFFE; cfg_hold = 32'd2; end
				8: begin cfg_debounce = $urandom_range(0, 50); cfg_hold = $urandom_range(0, 200); end
				default: begin cfg_debounce = $urandom; cfg_hold = $urandom; end
			endcase
			reg_write(REG_DEBOUNCE, cfg_debounce);
			reg_write(REG_HOLD, cfg_hold);
			ready_pat <= (ph % 3 == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
			run_phase(113, ph % 4 == 1);
			drain();
		end

		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ files.f @@
src/bdpc_pkg.sv
src/bdpc_if.sv
src/bdpc_lane.sv
src/bdpc_chord.sv
src/button_debounce_press_classifier.sv
sim/bdpc_action_checker.sv
sim/tb.sv
